// ----- hdl/dpsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dpsm_pkg
// Shared types and codes of the priority source merge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dpsm_pkg;

  typedef enum logic [2:0] {
    ACT_STAGE   = 3'd0,
    ACT_COMMIT  = 3'd1,
    ACT_TICK    = 3'd2,
    ACT_READ    = 3'd3,
    ACT_RELEASE = 3'd4
  } act_e;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NONE = 2'd1;
  localparam logic [1:0] STAT_LOSE = 2'd2;

  localparam logic [7:0] PRIO_MAX = 8'd200;

  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // Classified item as it travels from the front to the back
  typedef struct packed {
    logic [2:0] action;
    logic [2:0] src;
    logic       src_ok;
    logic [8:0] ch;
    logic       ch_ok;
    logic [7:0] lvl;
    logic [7:0] prio;
    logic [9:0] flen;
  } item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic [9:0] output_length;
    logic [7:0] winning_priority;
    logic       updated;
    logic [1:0] status;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/dpsm_front.sv -----
// ----------------------------------------------------------------------------
// dpsm_front
// Accepts input beats, range-checks and saturates them, and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsm_front #(
  parameter int NUM_SOURCES  = 8,
  parameter int NUM_CHANNELS = 512
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [2:0]     action_i,
  input  wire logic [2:0]     source_id_i,
  input  wire logic [8:0]     channel_i,
  input  wire logic [7:0]     level_i,
  input  wire logic [7:0]     priority_req_i,
  input  wire logic [9:0]     frame_length_i,
  input  wire logic           hold_i,
  output logic                item_valid_o,
  output dpsm_pkg::item_t     item_o,
  input  wire logic           item_pop_i
);
  import dpsm_pkg::*;

  localparam int QDEPTH = 4;

  item_t      queue_q [QDEPTH];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  item_t      item_in;
  logic       push;
  logic       pop;

  always_comb begin
    item_in.action = action_i;
    item_in.src    = source_id_i;
    item_in.src_ok = int'(source_id_i) < NUM_SOURCES;
    item_in.ch     = channel_i;
    item_in.ch_ok  = int'(channel_i) < NUM_CHANNELS;
    item_in.lvl    = level_i;
    item_in.prio   = (priority_req_i > PRIO_MAX) ? PRIO_MAX : priority_req_i;
    item_in.flen   = (int'(frame_length_i) > NUM_CHANNELS) ? 10'(NUM_CHANNELS)
                                                           : frame_length_i;
  end

  assign in_ready_o   = (count_q != 3'(QDEPTH)) && !hold_i;
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = count_q != 3'd0;
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 2'd1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 2'd1 : rd_ptr_q;
    count_d  = count_q + 3'(push) - 3'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dpsm_back.sv -----
// ----------------------------------------------------------------------------
// dpsm_back
// Sequencer that executes queued items: source frame store, source scan,
// merge walk and the merged output universe.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsm_back #(
  parameter int NUM_SOURCES  = 8,
  parameter int NUM_CHANNELS = 512
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  input  wire dpsm_pkg::item_t item_i,
  output logic                item_pop_o,
  output logic                clearing_o,
  input  wire logic           merge_mode_i,
  input  wire logic [15:0]    source_timeout_i,
  output logic                res_valid_o,
  output dpsm_pkg::result_t   res_o,
  input  wire logic           res_ready_i
);
  import dpsm_pkg::*;

  localparam int SW    = $clog2(NUM_SOURCES);
  localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DEPTH = NUM_SOURCES * NUM_CHANNELS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_DEC   = 8'b0000_1000,
    ST_MERGE = 8'b0001_0000,
    ST_DRAIN = 8'b0010_0000,
    ST_READ  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q;

  logic [7:0]  src_mem [DEPTH];
  logic [7:0]  merged_mem [NUM_CHANNELS];

  logic [7:0]  prio_q  [NUM_SOURCES];
  logic [9:0]  len_q   [NUM_SOURCES];
  logic [31:0] stamp_q [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] valid_q;

  logic [31:0] tick_q;
  logic [9:0]  merged_len_q;
  logic [7:0]  top_prio_q;
  logic [AW-1:0] clr_q;

  logic [SW-1:0] s_q;
  logic [CW-1:0] c_q;
  logic [SW-1:0] me_q;
  logic [7:0]    best_q;
  logic          any_q;
  logic [NUM_SOURCES-1:0] mask_q;
  logic [9:0]    maxlen_q;
  logic [9:0]    melen_q;

  result_t       res_q;
  logic          res_valid_q;

  // merge pipeline
  logic          p_valid_q;
  logic          p_sel_q;
  logic          p_first_q;
  logic          p_last_q;
  logic [CW-1:0] p_c_q;
  logic [7:0]    acc_q;
  logic [7:0]    term;
  logic [7:0]    accv;

  logic [7:0]    src_rdata_q;
  logic [7:0]    m_rdata_q;

  logic          src_we;
  logic [AW-1:0] src_waddr;
  logic [7:0]    src_wdata;
  logic [AW-1:0] src_raddr;
  logic [SW-1:0] item_idx;
  logic          act_s;
  logic [31:0]   age_s;
  logic          s_last;
  logic [NUM_SOURCES-1:0] s_bit;

  assign item_idx   = SW'(item_i.src);
  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;
  assign clearing_o = state_q == ST_CLEAR;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign age_s  = tick_q - stamp_q[s_q];
  assign act_s  = valid_q[s_q] && (len_q[s_q] != 10'd0) && (age_s < {16'd0, source_timeout_i});
  assign s_last = s_q == SW'(NUM_SOURCES - 1);
  assign s_bit  = NUM_SOURCES'(1) << s_q;

  always_comb begin
    src_we    = 1'b0;
    src_waddr = clr_q;
    src_wdata = 8'd0;
    if (state_q == ST_CLEAR) begin
      src_we = 1'b1;
    end else if (item_pop_o && (act_e'(item_i.action) == ACT_STAGE) &&
                 item_i.src_ok && item_i.ch_ok) begin
      src_we    = 1'b1;
      src_waddr = AW'(int'(item_idx) * NUM_CHANNELS + int'(item_i.ch));
      src_wdata = item_i.lvl;
    end
  end

  assign src_raddr = AW'(int'(s_q) * NUM_CHANNELS + int'(c_q));

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[src_waddr] <= src_wdata;
    end
    src_rdata_q <= src_mem[src_raddr];
  end

  always_comb begin
    term = p_sel_q ? src_rdata_q : 8'd0;
    accv = (p_first_q || (term > acc_q)) ? term : acc_q;
  end

  always_ff @(posedge clk_i) begin
    if (p_valid_q && p_last_q) begin
      merged_mem[p_c_q] <= accv;
    end
    m_rdata_q <= merged_mem[CW'(item_i.ch)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= state_q == ST_MERGE;
    end
  end

  always_ff @(posedge clk_i) begin
    p_sel_q   <= mask_q[s_q] && (10'(c_q) < len_q[s_q]);
    p_first_q <= s_q == '0;
    p_last_q  <= s_last;
    p_c_q     <= c_q;
    if (p_valid_q) begin
      acc_q <= accv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      valid_q      <= '0;
      tick_q       <= '0;
      merged_len_q <= '0;
      top_prio_q   <= '0;
      clr_q        <= '0;
      res_valid_q  <= 1'b0;
      s_q          <= '0;
      c_q          <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_valid_i) begin
            // a commit from a slot that does not exist loses outright
            res_q <= '{8'd0, merged_len_q, top_prio_q, 1'b0,
                       ((act_e'(item_i.action) == ACT_COMMIT) && !item_i.src_ok) ?
                       STAT_LOSE : STAT_OK};
            case (act_e'(item_i.action))
              ACT_COMMIT: begin
                if (item_i.src_ok) begin
                  prio_q[item_idx]  <= item_i.prio;
                  len_q[item_idx]   <= item_i.flen;
                  stamp_q[item_idx] <= tick_q;
                  valid_q[item_idx] <= 1'b1;
                  me_q     <= item_idx;
                  s_q      <= '0;
                  best_q   <= '0;
                  any_q    <= 1'b0;
                  mask_q   <= '0;
                  maxlen_q <= '0;
                  state_q  <= ST_SCAN;
                end else begin
                  state_q <= ST_OUT;
                end
              end
              ACT_TICK: begin
                tick_q  <= tick_q + 32'd1;
                state_q <= ST_OUT;
              end
              ACT_READ: begin
                state_q <= (10'(item_i.ch) < merged_len_q) ? ST_READ : ST_OUT;
              end
              ACT_RELEASE: begin
                if (item_i.src_ok) begin
                  valid_q[item_idx] <= 1'b0;
                end
                state_q <= ST_OUT;
              end
              default: begin
                state_q <= ST_OUT;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (act_s) begin
            if (!any_q || (prio_q[s_q] > best_q)) begin
              best_q   <= prio_q[s_q];
              mask_q   <= s_bit;
              maxlen_q <= len_q[s_q];
            end else if (prio_q[s_q] == best_q) begin
              mask_q <= mask_q | s_bit;
              if (len_q[s_q] > maxlen_q) begin
                maxlen_q <= len_q[s_q];
              end
            end
            any_q <= 1'b1;
          end
          if (s_q == me_q) begin
            melen_q <= len_q[s_q];
          end
          s_q <= s_last ? '0 : s_q + SW'(1);
          if (s_last) begin
            state_q <= ST_DEC;
          end
        end
        ST_DEC: begin
          top_prio_q <= any_q ? best_q : 8'd0;
          s_q        <= '0;
          c_q        <= '0;
          if (!any_q) begin
            res_q   <= '{8'd0, merged_len_q, 8'd0, 1'b0, STAT_NONE};
            state_q <= ST_OUT;
          end else if (!mask_q[me_q]) begin
            res_q   <= '{8'd0, merged_len_q, best_q, 1'b0, STAT_LOSE};
            state_q <= ST_OUT;
          end else begin
            // with merge mode off, the committer (the newest winner) is copied alone
            if (!merge_mode_i) begin
              mask_q   <= NUM_SOURCES'(1) << me_q;
              maxlen_q <= melen_q;
            end
            state_q <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          if (s_last) begin
            s_q <= '0;
            if (c_q == CW'(NUM_CHANNELS - 1)) begin
              state_q <= ST_DRAIN;
            end else begin
              c_q <= c_q + CW'(1);
            end
          end else begin
            s_q <= s_q + SW'(1);
          end
        end
        ST_DRAIN: begin
          merged_len_q <= maxlen_q;
          res_q        <= '{8'd0, maxlen_q, top_prio_q, 1'b1, STAT_OK};
          state_q      <= ST_OUT;
        end
        ST_READ: begin
          res_q.read_value <= m_rdata_q;
          state_q          <= ST_OUT;
        end
        ST_OUT: begin
          if (res_valid_q && res_ready_i) begin
            res_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end else begin
            res_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dmx_priority_source_merge_unit.sv -----
// ----------------------------------------------------------------------------
// dmx_priority_source_merge_unit
// Priority merge of lighting source frames into one output universe.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the source frame memory to zero, one entry a
// cycle, over NUM_SOURCES*NUM_CHANNELS entries (4096 at the defaults), and
// takes no beat meanwhile. Input beats enter a four-deep queue; the sequencer
// behind it runs one item at a time. Stage, tick, release and unknown actions
// go from idle straight to the output state; a read in range passes a read
// state first. A commit scans the sources one per cycle and, when the
// committer wins, walks the frame memory once per source per channel through
// its single read port.
`default_nettype none

module dmx_priority_source_merge_unit #(
  parameter int NUM_SOURCES  = 8,
  parameter int NUM_CHANNELS = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [2:0]  source_id_i,
  input  wire logic [8:0]  channel_i,
  input  wire logic [7:0]  level_i,
  input  wire logic [7:0]  priority_req_i,
  input  wire logic [9:0]  frame_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_value_o,
  output logic [9:0]       output_length_o,
  output logic [7:0]       winning_priority_o,
  output logic             updated_o,
  output logic [1:0]       status_o
);
  import dpsm_pkg::*;

  logic        merge_mode_q;
  logic [15:0] timeout_q;
  logic        clearing;
  logic        item_valid;
  logic        item_pop;
  item_t       item;
  result_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_mode_q <= 1'b0;
      timeout_q    <= 16'd2500;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MODE) begin
        merge_mode_q <= cfg_data_i[0];
      end
      if (cfg_idx_i == CFG_TIMEOUT) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  dpsm_front #(
    .NUM_SOURCES (NUM_SOURCES),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .source_id_i   (source_id_i),
    .channel_i     (channel_i),
    .level_i       (level_i),
    .priority_req_i(priority_req_i),
    .frame_length_i(frame_length_i),
    .hold_i        (clearing),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  dpsm_back #(
    .NUM_SOURCES (NUM_SOURCES),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_pop_o      (item_pop),
    .clearing_o      (clearing),
    .merge_mode_i    (merge_mode_q),
    .source_timeout_i(timeout_q),
    .res_valid_o     (out_valid_o),
    .res_o           (res),
    .res_ready_i     (out_ready_i)
  );

  assign read_value_o       = res.read_value;
  assign output_length_o    = res.output_length;
  assign winning_priority_o = res.winning_priority;
  assign updated_o          = res.updated;
  assign status_o           = res.status;

`ifndef NO_ASSERTIONS
  a_no_accept_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !in_ready_o)
    else $error("beat accepted during memory clear");

  a_update_is_ok: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (out_valid_o && updated_o) |->
      (status_o == STAT_OK && int'(output_length_o) <= NUM_CHANNELS))
    else $error("update with bad status or length");

  a_prio_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> winning_priority_o <= PRIO_MAX)
    else $error("winning priority out of range");

  a_read_only_value: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (out_valid_o && read_value_o != 8'd0) |->
      (!updated_o && status_o == STAT_OK))
    else $error("read value on a non-read result");
`endif

endmodule

`default_nettype wire
